FILE: rtl/bwrld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwrld_pkg
// shared types and constants of the bit window run length decoder
// ----------------------------------------------------------------------------
package bwrld_pkg;

	localparam int unsigned SYM_MAX    = 8;
	localparam int unsigned CNT_MAX    = 5;
	localparam int unsigned RESULT_CAP = 64;

	localparam logic [3:0]  SYM_BITS_RST  = 4'd5;
	localparam logic [2:0]  CNT_BITS_RST  = 3'd5;
	localparam logic [12:0] SYM_LIMIT_RST = 13'd256;

	typedef enum logic [1:0] {
		REG_SYMBOL_BITS  = 2'd0,
		REG_COUNT_BITS   = 2'd1,
		REG_SYMBOL_LIMIT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		logic [3:0]  symbol_bits;
		logic [2:0]  count_bits;
		logic [12:0] symbol_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       has_symbol;
		logic       item_last;
		logic       stream_done;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/bwrld_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwrld_front
// input side: two entry item queue in front of the decode sequencer
// ----------------------------------------------------------------------------
module bwrld_front import bwrld_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] data_byte,
	input  wire logic       stream_end,
	output logic            full,
	output item_t           item,
	output logic            item_valid,
	input  wire logic       item_take
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// payload store
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= '{data_byte: data_byte, stream_end: stream_end};
		end
	end

	a_full_no_valid_loss : assert property (@(posedge clk) disable iff (!arst_n)
		full |-> item_valid)
		else $error("queue full without a waiting item");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("queue count did not advance on push");

	a_ptr_gap : assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers out of step");

endmodule
`default_nettype wire

FILE: rtl/bwrld_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bwrld_back
// decode sequencer: one field read or one repeated symbol per cycle when not stalled by a full
// output side, with a held result and an output register toward the result side
// ----------------------------------------------------------------------------
module bwrld_back import bwrld_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire item_t item,
	input  wire logic  item_valid,
	output logic       item_take,
	output res_t       res,
	output logic       empty,
	input  wire logic  pop
);

	typedef enum logic [1:0] {
		S_LOAD,
		S_RUN,
		S_MARK,
		S_FLUSH
	} state_t;

	state_t      state_q;
	logic [15:0] buf_q;
	logic [4:0]  held_q;
	logic        expect_q;
	logic [7:0]  prior_q;
	logic        prior_v_q;
	logic [12:0] emitted_q;
	logic [4:0]  rep_q;
	logic [6:0]  k_q;
	logic        last_q;
	logic        pend_v_q;
	res_t        pend_q;
	logic        out_v_q;
	res_t        out_q;

	logic [3:0]  sb;
	logic [3:0]  cb;
	logic [3:0]  fld_n;
	logic [4:0]  held_after;
	logic [15:0] fld_raw;
	logic [7:0]  fld_v;
	logic [15:0] buf_keep;
	logic        can_take;
	logic        below_lim;
	logic [6:0]  cap;
	logic        room_k;
	logic        out_room;
	logic        ok_adv;

	always_comb begin
		priority if (cfg.symbol_bits == 4'd0) begin
			sb = 4'd1;
		end else if (cfg.symbol_bits > 4'(SYM_MAX)) begin
			sb = 4'(SYM_MAX);
		end else begin
			sb = cfg.symbol_bits;
		end
		priority if (cfg.count_bits == 3'd0) begin
			cb = 4'd1;
		end else if ({1'b0, cfg.count_bits} > 4'(CNT_MAX)) begin
			cb = 4'(CNT_MAX);
		end else begin
			cb = {1'b0, cfg.count_bits};
		end
	end

	assign fld_n      = expect_q ? cb : sb;
	assign can_take   = (held_q >= {1'b0, fld_n});
	assign held_after = held_q - {1'b0, fld_n};
	assign fld_raw    = buf_q >> held_after;
	assign fld_v      = fld_raw[7:0] & (8'hFF >> (4'd8 - fld_n));
	assign buf_keep   = buf_q & ~(16'hFFFF << held_after);
	assign below_lim  = (emitted_q < cfg.symbol_limit);
	assign cap        = last_q ? 7'(RESULT_CAP - 1) : 7'(RESULT_CAP);
	assign room_k     = (k_q < cap);
	assign out_room   = !out_v_q || pop;
	assign ok_adv     = !pend_v_q || out_room;

	assign item_take  = (state_q == S_LOAD) && item_valid;
	assign empty      = !out_v_q;
	assign res        = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			buf_q     <= '0;
			held_q    <= '0;
			expect_q  <= 1'b0;
			prior_q   <= '0;
			prior_v_q <= 1'b0;
			emitted_q <= '0;
			rep_q     <= '0;
			k_q       <= '0;
			last_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			pend_q    <= '0;
			out_v_q   <= 1'b0;
			out_q     <= '0;
		end else begin
			if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (item_valid) begin
						last_q <= item.stream_end;
						k_q    <= '0;
						if (below_lim) begin
							buf_q  <= {buf_q[7:0], item.data_byte};
							held_q <= held_q + 5'd8;
						end
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (ok_adv) begin
						priority if (rep_q != 5'd0) begin
							if (below_lim) begin
								rep_q <= rep_q - 5'd1;
								if (room_k) begin
									if (pend_v_q) begin
										out_v_q <= 1'b1;
										out_q   <= '{pend_q.symbol, pend_q.has_symbol, 1'b0,
										             pend_q.stream_done};
									end
									pend_v_q  <= 1'b1;
									pend_q    <= '{prior_q, 1'b1, 1'b0, 1'b0};
									k_q       <= k_q + 7'd1;
									emitted_q <= emitted_q + 13'd1;
								end
							end else begin
								rep_q <= '0;
							end
						end else if (!below_lim) begin
							state_q <= last_q ? S_MARK : S_FLUSH;
						end else if (!expect_q) begin
							if (!can_take) begin
								state_q <= last_q ? S_MARK : S_FLUSH;
							end else begin
								held_q <= held_after;
								buf_q  <= buf_keep;
								if (room_k) begin
									if (pend_v_q) begin
										out_v_q <= 1'b1;
										out_q   <= '{pend_q.symbol, pend_q.has_symbol, 1'b0,
										             pend_q.stream_done};
									end
									pend_v_q  <= 1'b1;
									pend_q    <= '{fld_v, 1'b1, 1'b0, 1'b0};
									k_q       <= k_q + 7'd1;
									emitted_q <= emitted_q + 13'd1;
								end
								if (prior_v_q && (fld_v == prior_q)) begin
									expect_q <= 1'b1;
								end else begin
									prior_q   <= fld_v;
									prior_v_q <= 1'b1;
								end
							end
						end else begin
							if (!can_take) begin
								if (last_q) begin
									expect_q  <= 1'b0;
									prior_v_q <= 1'b0;
								end
								state_q <= last_q ? S_MARK : S_FLUSH;
							end else begin
								held_q    <= held_after;
								buf_q     <= buf_keep;
								rep_q     <= fld_v[4:0];
								expect_q  <= 1'b0;
								prior_v_q <= 1'b0;
							end
						end
					end
				end
				S_MARK: begin
					if (ok_adv) begin
						if (pend_v_q) begin
							out_v_q <= 1'b1;
							out_q   <= '{pend_q.symbol, pend_q.has_symbol, 1'b0,
							             pend_q.stream_done};
						end
						pend_v_q  <= 1'b1;
						pend_q    <= '{8'd0, 1'b0, 1'b0, 1'b1};
						buf_q     <= '0;
						held_q    <= '0;
						expect_q  <= 1'b0;
						prior_q   <= '0;
						prior_v_q <= 1'b0;
						emitted_q <= '0;
						rep_q     <= '0;
						state_q   <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_LOAD;
					end else if (out_room) begin
						out_v_q  <= 1'b1;
						out_q    <= '{pend_q.symbol, pend_q.has_symbol, 1'b1,
						              pend_q.stream_done};
						pend_v_q <= 1'b0;
						state_q  <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	a_marker_closes : assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.stream_done) |-> (out_q.item_last && !out_q.has_symbol))
		else $error("end marker not shaped as last result");

	a_load_no_pend : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> !pend_v_q)
		else $error("held result left behind between items");

	a_rep_not_expect : assert property (@(posedge clk) disable iff (!arst_n)
		(rep_q != 5'd0) |-> !expect_q)
		else $error("repeat running while count expected");

	a_mark_clears : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK && ok_adv) |=> (emitted_q == 13'd0 && held_q == 5'd0))
		else $error("stream state not cleared after end marker");

	a_k_bound : assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 7'(RESULT_CAP))
		else $error("result count per item overran");

endmodule
`default_nettype wire

FILE: rtl/bit_window_run_length_decoder_core.sv
`default_nettype none
// a byte's first result goes from the shift buffer to the held result, then to the output register
// when another result follows, else when the item is flushed
// an item passes load, then run with one step per field read and one per repeated symbol,
// plus one to close the read loop, then the end marker on the final byte, then flush
// the decode sequencer (one field or one repeat a cycle while the output side has room) sets the rate
// reset (arst_n low) clears both queues and the stream state, registers take defaults
// ----------------------------------------------------------------------------
// bit_window_run_length_decoder_core
// run length decoder over a packed msb-first symbol stream, with apb registers
// ----------------------------------------------------------------------------
module bit_window_run_length_decoder_core import bwrld_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        stream_end,
	output logic             empty,
	input  wire logic        pop,
	output logic      [7:0]  symbol,
	output logic             has_symbol,
	output logic             item_last,
	output logic             stream_done
);

	cfg_t     cfg_q;
	item_t    item;
	logic     item_valid;
	logic     item_take;
	res_t     res;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.symbol_bits  <= SYM_BITS_RST;
			cfg_q.count_bits   <= CNT_BITS_RST;
			cfg_q.symbol_limit <= SYM_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_SYMBOL_BITS:  cfg_q.symbol_bits  <= pwdata[3:0];
				REG_COUNT_BITS:   cfg_q.count_bits   <= pwdata[2:0];
				REG_SYMBOL_LIMIT: cfg_q.symbol_limit <= pwdata[12:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SYMBOL_BITS:  prdata = {28'd0, cfg_q.symbol_bits};
			REG_COUNT_BITS:   prdata = {29'd0, cfg_q.count_bits};
			REG_SYMBOL_LIMIT: prdata = {19'd0, cfg_q.symbol_limit};
			default:          prdata = 32'd0;
		endcase
	end

	bwrld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.full       (full),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take)
	);

	bwrld_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (item),
		.item_valid (item_valid),
		.item_take  (item_take),
		.res        (res),
		.empty      (empty),
		.pop        (pop)
	);

	assign symbol      = res.symbol;
	assign has_symbol  = res.has_symbol;
	assign item_last   = res.item_last;
	assign stream_done = res.stream_done;

endmodule
`default_nettype wire
